FILE: rtl/rngb_pkg.sv
// ----------------------------------------------------------------------------
// rngb_pkg
// Shared types, widths and helpers of the run-length gray blitter.
// ----------------------------------------------------------------------------
package rngb_pkg;

  localparam int unsigned MAX_ROW_PAIRS_DEF    = 512;
  localparam int unsigned MAX_IMAGE_ROWS_DEF   = 1024;
  localparam int unsigned CANVAS_ADDR_BITS_DEF = 20;

  // fixed field widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned PAIRS_W    = 10;
  localparam int unsigned ROW_W      = 11;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned MUL_W      = 12;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_W + 1);
  localparam int unsigned ADDR_SUM_W = PROD_W + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PAIRS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_X         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_Y         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_FIRST_ROW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_ROWS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_STRIDE  = 3'd6;

  localparam logic [PAIRS_W-1:0] MIN_PAIRS = 10'd5;

  typedef struct packed {
    logic [9:0]  image_pairs;
    logic [10:0] image_height;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [9:0]  crop_first_row;
    logic [10:0] crop_rows;
    logic [11:0] canvas_stride;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] op_a;
    logic [MUL_W-1:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // 4-bit gray widened to 8 bits: n * 17 is the nibble repeated
  function automatic logic [7:0] gray_of(input logic [3:0] n);
    gray_of = {n, n};
  endfunction

endpackage

FILE: rtl/rngb_mul.sv
// ----------------------------------------------------------------------------
// rngb_mul
// Shift-add multiplier, one multiplier bit per cycle, for row addresses.
// ----------------------------------------------------------------------------
module rngb_mul (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rngb_pkg::mul_req_t                   req,
  output rngb_pkg::mul_stat_t                  stat,
  output logic [rngb_pkg::PROD_W-1:0]          product
);

  logic [rngb_pkg::PROD_W-1:0]    acc_r, acc_nxt;
  logic [rngb_pkg::PROD_W-1:0]    mcand_r, mcand_nxt;
  logic [rngb_pkg::MUL_W-1:0]     mplier_r, mplier_nxt;
  logic [rngb_pkg::MUL_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    run_nxt    = run_r;
    done_nxt   = 1'b0;
    if (req.start) begin
      acc_nxt    = '0;
      mcand_nxt  = rngb_pkg::PROD_W'(req.op_a);
      mplier_nxt = req.op_b;
      cnt_nxt    = rngb_pkg::MUL_CNT_W'(rngb_pkg::MUL_W);
      run_nxt    = 1'b1;
    end else if (run_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == rngb_pkg::MUL_CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign stat.busy = run_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

FILE: rtl/rngb_seq.sv
// ----------------------------------------------------------------------------
// rngb_seq
// Byte parser, column/row tracker and span sequencer with output register.
// ----------------------------------------------------------------------------
module rngb_seq #(
  parameter int unsigned MAX_ROW_PAIRS    = rngb_pkg::MAX_ROW_PAIRS_DEF,
  parameter int unsigned MAX_IMAGE_ROWS   = rngb_pkg::MAX_IMAGE_ROWS_DEF,
  parameter int unsigned CANVAS_ADDR_BITS = rngb_pkg::CANVAS_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rngb_pkg::cfg_t                      cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic                                in_start_image,
  output rngb_pkg::mul_req_t                  mul_req,
  input  rngb_pkg::mul_stat_t                 mul_stat,
  input  logic [rngb_pkg::PROD_W-1:0]         mul_product,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CANVAS_ADDR_BITS-1:0]         out_pixel_address,
  output logic [9:0]                          out_pair_count,
  output logic [7:0]                          out_left_gray,
  output logic [7:0]                          out_right_gray,
  output logic                                out_last_of_run,
  output logic                                out_image_done
);

  localparam int unsigned SUM_W = (CANVAS_ADDR_BITS > rngb_pkg::ADDR_SUM_W) ?
                                  CANVAS_ADDR_BITS : rngb_pkg::ADDR_SUM_W;
  localparam int unsigned PW = rngb_pkg::PAIRS_W;
  localparam int unsigned RW = rngb_pkg::ROW_W;
  localparam int unsigned SW = rngb_pkg::SEG_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_SEG    = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_EMIT   = 6'b010000,
    ST_STEP   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    PH_HEAD  = 2'd0,
    PH_COUNT = 2'd1,
    PH_LIT   = 2'd2,
    PH_VALUE = 2'd3
  } phase_t;

  state_t        state_r, state_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    bytes_left_r, bytes_left_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          finished_r, finished_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] seg_r, seg_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [CANVAS_ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [9:0]                  cnt_r, cnt_nxt;
  logic [7:0]                  lgray_r, lgray_nxt;
  logic [7:0]                  rgray_r, rgray_nxt;
  logic                        last_r, last_nxt;
  logic                        done_r, done_nxt;

  // effective geometry
  logic [PW-1:0] pairs;
  logic [RW-1:0] height;
  logic [RW:0]   win_sum;
  logic [RW-1:0] win_end;

  always_comb begin
    pairs = cfg.image_pairs;
    if (cfg.image_pairs < rngb_pkg::MIN_PAIRS) begin
      pairs = rngb_pkg::MIN_PAIRS;
    end else if (13'(cfg.image_pairs) > 13'(MAX_ROW_PAIRS)) begin
      pairs = PW'(MAX_ROW_PAIRS);
    end
    height = cfg.image_height;
    if (14'(cfg.image_height) > 14'(MAX_IMAGE_ROWS)) begin
      height = RW'(MAX_IMAGE_ROWS);
    end
    win_sum = (RW+1)'(cfg.crop_first_row) + (RW+1)'(cfg.crop_rows);
    if (height == '0 || cfg.crop_rows == '0 || RW'(cfg.crop_first_row) >= height) begin
      win_end = '0;
    end else if (win_sum < (RW+1)'(height)) begin
      win_end = RW'(win_sum);
    end else begin
      win_end = height;
    end
  end

  // segment of the current row
  logic [PW-1:0] room;
  logic [SW-1:0] seg_c;
  logic          kept;

  assign room  = pairs - col_r;
  assign seg_c = (PW'(rem_r) < room) ? rem_r : SW'(room);
  assign kept  = row_r >= RW'(cfg.crop_first_row);

  // column/row advance by seg_r
  logic [PW:0]   col_sum;
  logic          row_end;
  logic [RW:0]   row_inc;
  logic          fin;
  logic [SW-1:0] rem_left;
  logic          item_end;

  assign col_sum  = (PW+1)'(col_r) + (PW+1)'(seg_r);
  assign row_end  = col_sum >= (PW+1)'(pairs);
  assign row_inc  = (RW+1)'(row_r) + 1'b1;
  assign fin      = row_end && (row_inc >= (RW+1)'(win_end));
  assign rem_left = rem_r - seg_r;
  assign item_end = (rem_left == '0) || fin;

  logic [SUM_W-1:0] addr_sum;
  assign addr_sum = SUM_W'(mul_product) + SUM_W'(cfg.dest_x) + SUM_W'({col_r, 1'b0});

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  logic [RW-1:0] row_off;
  assign row_off = row_r - RW'(cfg.crop_first_row);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    finished_nxt   = finished_r;
    byte_nxt       = byte_r;
    rem_nxt        = rem_r;
    seg_nxt        = seg_r;
    out_valid_nxt  = out_valid_r && out_stall;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    lgray_nxt      = lgray_r;
    rgray_nxt      = rgray_r;
    last_nxt       = last_r;
    done_nxt       = done_r;
    mul_req.start  = 1'b0;
    mul_req.op_a   = rngb_pkg::MUL_W'(cfg.dest_y) + rngb_pkg::MUL_W'(row_off);
    mul_req.op_b   = cfg.canvas_stride;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_stream_byte;
          state_nxt = ST_DECODE;
          if (in_start_image) begin
            phase_nxt      = PH_HEAD;
            bytes_left_nxt = '0;
            col_nxt        = '0;
            row_nxt        = '0;
            finished_nxt   = 1'b0;
          end
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        if (!(finished_r || win_end == '0 || row_r >= win_end)) begin
          unique case (phase_r)
            PH_HEAD: begin
              if (byte_r == '0) begin
                phase_nxt = PH_COUNT;
              end else begin
                bytes_left_nxt = byte_r;
                phase_nxt      = PH_VALUE;
              end
            end
            PH_COUNT: begin
              if (byte_r == '0) begin
                phase_nxt = PH_HEAD;
              end else begin
                bytes_left_nxt = byte_r;
                phase_nxt      = PH_LIT;
              end
            end
            PH_LIT: begin
              rem_nxt        = SW'(1);
              bytes_left_nxt = bytes_left_r - 1'b1;
              if (bytes_left_r == 8'd1) begin
                phase_nxt = PH_HEAD;
              end
              state_nxt = ST_SEG;
            end
            PH_VALUE: begin
              rem_nxt        = bytes_left_r;
              bytes_left_nxt = '0;
              phase_nxt      = PH_HEAD;
              state_nxt      = ST_SEG;
            end
            default: begin
              phase_nxt = PH_HEAD;
            end
          endcase
        end
      end
      ST_SEG: begin
        seg_nxt = seg_c;
        if (kept) begin
          mul_req.start = 1'b1;
          state_nxt     = ST_MUL;
        end else begin
          state_nxt = ST_STEP;
        end
      end
      ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          addr_nxt      = addr_sum[CANVAS_ADDR_BITS-1:0];
          cnt_nxt       = 10'(seg_r);
          lgray_nxt     = rngb_pkg::gray_of(byte_r[7:4]);
          rgray_nxt     = rngb_pkg::gray_of(byte_r[3:0]);
          last_nxt      = item_end;
          done_nxt      = fin;
          col_nxt       = row_end ? '0 : PW'(col_sum);
          row_nxt       = row_end ? RW'(row_inc) : row_r;
          finished_nxt  = finished_r || fin;
          rem_nxt       = rem_left;
          state_nxt     = item_end ? ST_IDLE : ST_SEG;
        end
      end
      ST_STEP: begin
        // rows above the crop window: advance only
        col_nxt      = row_end ? '0 : PW'(col_sum);
        row_nxt      = row_end ? RW'(row_inc) : row_r;
        finished_nxt = finished_r || fin;
        rem_nxt      = rem_left;
        state_nxt    = item_end ? ST_IDLE : ST_SEG;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      phase_r      <= PH_HEAD;
      bytes_left_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      finished_r   <= 1'b0;
      rem_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      finished_r   <= finished_nxt;
      rem_r        <= rem_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_r  <= byte_nxt;
    seg_r   <= seg_nxt;
    addr_r  <= addr_nxt;
    cnt_r   <= cnt_nxt;
    lgray_r <= lgray_nxt;
    rgray_r <= rgray_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
  end

  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pair_count    = cnt_r;
  assign out_left_gray     = lgray_r;
  assign out_right_gray    = rgray_r;
  assign out_last_of_run   = last_r;
  assign out_image_done    = done_r;

endmodule

FILE: rtl/rle_nibble_gray_blitter_top.sv
// ----------------------------------------------------------------------------
// rle_nibble_gray_blitter_top
// Run-length 4bpp stream decoder emitting 8bpp gray spans with canvas address.
//
//   port group  direction  handshake           payload
//   in_*        input      in_valid/in_stall   stream_byte, start_image
//   out_*       output     out_valid/out_stall address, pair count, grays, flags
//   cfg_*       input      cfg_valid/cfg_ready register index, write data
//
// a byte is taken only in idle; a header or dropped byte passes idle and decode,
// a pixel byte then segment, multiply (waiting on the shift-add multiplier for the
// row address) and emit per kept span; segment and step per skipped row segment.
// reset is synchronous; config registers come up at their defaults.
// a result waits in the output register while the next span is computed;
// out_stall only holds up the sequencer when the next span is ready to load.
// ----------------------------------------------------------------------------
module rle_nibble_gray_blitter_top #(
  parameter int unsigned MAX_ROW_PAIRS    = rngb_pkg::MAX_ROW_PAIRS_DEF,
  parameter int unsigned MAX_IMAGE_ROWS   = rngb_pkg::MAX_IMAGE_ROWS_DEF,
  parameter int unsigned CANVAS_ADDR_BITS = rngb_pkg::CANVAS_ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic                                in_start_image,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [CANVAS_ADDR_BITS-1:0]         out_pixel_address,
  output logic [9:0]                          out_pair_count,
  output logic [7:0]                          out_left_gray,
  output logic [7:0]                          out_right_gray,
  output logic                                out_last_of_run,
  output logic                                out_image_done,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rngb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rngb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  rngb_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rngb_pkg::REG_IMAGE_PAIRS:    cfg_nxt.image_pairs    = cfg_data[9:0];
        rngb_pkg::REG_IMAGE_HEIGHT:   cfg_nxt.image_height   = cfg_data[10:0];
        rngb_pkg::REG_DEST_X:         cfg_nxt.dest_x         = cfg_data[10:0];
        rngb_pkg::REG_DEST_Y:         cfg_nxt.dest_y         = cfg_data[10:0];
        rngb_pkg::REG_CROP_FIRST_ROW: cfg_nxt.crop_first_row = cfg_data[9:0];
        rngb_pkg::REG_CROP_ROWS:      cfg_nxt.crop_rows      = cfg_data[10:0];
        rngb_pkg::REG_CANVAS_STRIDE:  cfg_nxt.canvas_stride  = cfg_data[11:0];
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_pairs    <= 10'd5;
      cfg_r.image_height   <= 11'd1;
      cfg_r.dest_x         <= '0;
      cfg_r.dest_y         <= '0;
      cfg_r.crop_first_row <= '0;
      cfg_r.crop_rows      <= 11'd1024;
      cfg_r.canvas_stride  <= 12'd960;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_ready = 1'b1;

  rngb_pkg::mul_req_t          mul_req;
  rngb_pkg::mul_stat_t         mul_stat;
  logic [rngb_pkg::PROD_W-1:0] mul_product;

  rngb_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req),
    .stat    (mul_stat),
    .product (mul_product)
  );

  rngb_seq #(
    .MAX_ROW_PAIRS    (MAX_ROW_PAIRS),
    .MAX_IMAGE_ROWS   (MAX_IMAGE_ROWS),
    .CANVAS_ADDR_BITS (CANVAS_ADDR_BITS)
  ) u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_stream_byte    (in_stream_byte),
    .in_start_image    (in_start_image),
    .mul_req           (mul_req),
    .mul_stat          (mul_stat),
    .mul_product       (mul_product),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pair_count    (out_pair_count),
    .out_left_gray     (out_left_gray),
    .out_right_gray    (out_right_gray),
    .out_last_of_run   (out_last_of_run),
    .out_image_done    (out_image_done)
  );

endmodule
